// ===== rtl/pcg_pkg.sv =====
// Shared types, register codes and masks for the peripheral clock gate registers.
// No dependencies; used by every module of the block except pcg_ram.
package pcg_pkg;

    localparam int NUM_PERIPH  = 64;
    localparam int FIRST_GATED = 2;
    localparam int MAP_W       = 64;
    localparam int ID_W        = 6;
    localparam int DIV_W       = 2;

    localparam int CTL_CMD_BIT   = 12;
    localparam int CTL_DIV_SHIFT = 16;
    localparam int CTL_EN_BIT    = 28;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] REG_SET_LO   = 3'd0;
    localparam logic [2:0] REG_CLR_LO   = 3'd1;
    localparam logic [2:0] REG_STAT_LO  = 3'd2;
    localparam logic [2:0] REG_SET_HI   = 3'd3;
    localparam logic [2:0] REG_CLR_HI   = 3'd4;
    localparam logic [2:0] REG_STAT_HI  = 3'd5;
    localparam logic [2:0] REG_CTRL     = 3'd6;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic        op;
        logic [2:0]  reg_sel;
        logic [31:0] wdata;
    } t_req;

    typedef struct packed {
        logic [31:0] rdata;
        logic        bad_reg;
    } t_rsp;

    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   addr;
        logic [DIV_W-1:0]  div;
    } t_div_wr;

    function automatic logic id_exists(input logic [ID_W-1:0] id);
        return ({1'b0, id} < (ID_W+1)'(NUM_PERIPH));
    endfunction

    function automatic logic id_gated(input logic [ID_W-1:0] id);
        return id_exists(id) && ({1'b0, id} >= (ID_W+1)'(FIRST_GATED));
    endfunction

    function automatic logic [MAP_W-1:0] f_gated_mask();
        logic [MAP_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAP_W; i++) begin
            m[i] = (i < NUM_PERIPH) && (i >= FIRST_GATED);
        end
        return m;
    endfunction

    function automatic logic [MAP_W-1:0] f_forced_mask();
        logic [MAP_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAP_W; i++) begin
            m[i] = (i < NUM_PERIPH) && (i < FIRST_GATED);
        end
        return m;
    endfunction

    localparam logic [MAP_W-1:0] GATED_MASK  = f_gated_mask();
    localparam logic [MAP_W-1:0] FORCED_MASK = f_forced_mask();

endpackage

// ===== rtl/pcg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcg_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcg_div_store.sv =====
// Per-peripheral divider store: RAM, per-entry valid bits and write bypass.
// Depends on pcg_pkg and pcg_ram.
module pcg_div_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcg_pkg::t_div_wr               i_wr,
    input  logic [pcg_pkg::ID_W-1:0]       i_raddr,
    output logic [pcg_pkg::DIV_W-1:0]      o_div
);

    localparam int DEPTH = 1 << pcg_pkg::ID_W;

    logic [DEPTH-1:0]              r_valid;
    logic                          r_rvalid;
    logic                          r_byp;
    logic [pcg_pkg::DIV_W-1:0]     r_byp_div;
    logic [pcg_pkg::DIV_W-1:0]     ram_q;
    logic                          hit;

    pcg_ram #(
        .WIDTH (pcg_pkg::DIV_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.div),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    assign hit = i_wr.en && (i_wr.addr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
            r_byp    <= hit;
        end
        r_byp_div <= i_wr.div;
    end

    assign o_div = r_byp ? r_byp_div : (r_rvalid ? ram_q : '0);

endmodule

// ===== rtl/peripheral_clock_gate_regs.sv =====
// Top level of the peripheral clock gate registers: request register, register
// logic, enable map and result register. Depends on pcg_pkg and pcg_div_store.
//
// One request is taken per cycle while o_busy is low (it is high during reset and
// in the first cycle after it). Each request gives one response on o_rsp, marked
// by o_done for one cycle, after it has passed the request register and then
// the register logic into the result register. The response must be captured in
// that cycle. Control reads see every earlier write.
module peripheral_clock_gate_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pcg_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_done,
    output pcg_pkg::t_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_vld;
    pcg_pkg::t_req                 r_req;
    logic                          r_done;
    pcg_pkg::t_rsp                 r_rsp;
    logic [pcg_pkg::MAP_W-1:0]     r_en_map;
    logic [pcg_pkg::ID_W-1:0]      r_sel;

    logic [pcg_pkg::MAP_W-1:0]     n_en_map;
    logic [pcg_pkg::ID_W-1:0]      n_sel;
    pcg_pkg::t_rsp                 n_rsp;
    pcg_pkg::t_div_wr              div_wr;
    logic [pcg_pkg::DIV_W-1:0]     sel_div;

    logic [pcg_pkg::MAP_W-1:0]     status;
    logic [pcg_pkg::MAP_W-1:0]     bits;
    logic                          is_wr;
    logic [pcg_pkg::ID_W-1:0]      wr_id;
    logic                          accept;

    assign accept = i_start && !r_busy;
    assign status = (r_en_map & pcg_pkg::GATED_MASK) | pcg_pkg::FORCED_MASK;
    assign is_wr  = (r_req.op == pcg_pkg::OP_WRITE);
    assign wr_id  = r_req.wdata[pcg_pkg::ID_W-1:0];

    always_comb begin
        n_en_map    = r_en_map;
        n_sel       = r_sel;
        n_rsp       = '0;
        div_wr      = '0;
        div_wr.addr = wr_id;
        div_wr.div  = r_req.wdata[pcg_pkg::CTL_DIV_SHIFT +: pcg_pkg::DIV_W];
        bits        = '0;
        if (r_vld) begin
            case (r_req.reg_sel)
                pcg_pkg::REG_SET_LO, pcg_pkg::REG_SET_HI: begin
                    if (r_req.reg_sel == pcg_pkg::REG_SET_HI) begin
                        bits = {r_req.wdata, 32'd0};
                    end else begin
                        bits = {32'd0, r_req.wdata};
                    end
                    if (is_wr) begin
                        n_en_map = r_en_map | (bits & pcg_pkg::GATED_MASK);
                    end
                end
                pcg_pkg::REG_CLR_LO, pcg_pkg::REG_CLR_HI: begin
                    if (r_req.reg_sel == pcg_pkg::REG_CLR_HI) begin
                        bits = {r_req.wdata, 32'd0};
                    end else begin
                        bits = {32'd0, r_req.wdata};
                    end
                    if (is_wr) begin
                        n_en_map = r_en_map & ~(bits & pcg_pkg::GATED_MASK);
                    end
                end
                pcg_pkg::REG_STAT_LO: begin
                    if (!is_wr) begin
                        n_rsp.rdata = status[31:0];
                    end
                end
                pcg_pkg::REG_STAT_HI: begin
                    if (!is_wr) begin
                        n_rsp.rdata = status[63:32];
                    end
                end
                pcg_pkg::REG_CTRL: begin
                    if (is_wr) begin
                        n_sel = wr_id;
                        if (r_req.wdata[pcg_pkg::CTL_CMD_BIT] && pcg_pkg::id_gated(wr_id)) begin
                            div_wr.en = 1'b1;
                            n_en_map[wr_id] = r_req.wdata[pcg_pkg::CTL_EN_BIT];
                        end
                    end else begin
                        n_rsp.rdata[pcg_pkg::ID_W-1:0] = r_sel;
                        if (pcg_pkg::id_exists(r_sel)) begin
                            n_rsp.rdata[pcg_pkg::CTL_DIV_SHIFT +: pcg_pkg::DIV_W] = sel_div;
                            n_rsp.rdata[pcg_pkg::CTL_EN_BIT] = status[r_sel];
                        end
                    end
                end
                default: begin
                    n_rsp.bad_reg = 1'b1;
                end
            endcase
        end
    end

    // divider of the selected peripheral is read at its next id, so it lines up with r_sel
    pcg_div_store u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (div_wr),
        .i_raddr (n_sel),
        .o_div   (sel_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_vld    <= 1'b0;
            r_done   <= 1'b0;
            r_en_map <= '0;
            r_sel    <= '0;
        end else begin
            r_busy   <= 1'b0;
            r_vld    <= accept;
            r_done   <= r_vld;
            r_en_map <= n_en_map;
            r_sel    <= n_sel;
        end
        if (accept) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    ap_done_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("request without response");

    ap_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 2))
        else $error("response without request");

    ap_ungated_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_en_map & ~pcg_pkg::GATED_MASK) == '0)
        else $error("ungated peripheral bit stored in enable map");

    ap_bad_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.bad_reg) |-> (o_rsp.rdata == '0))
        else $error("unknown register returned data");

endmodule

// ===== verif/pcg_gate_checker.sv =====
// Checker for the peripheral clock gate registers: follows requests and responses,
// keeps its own enable map, divider table and selected id, and compares every response.
// Depends on pcg_pkg.
module pcg_gate_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  pcg_pkg::t_req  i_req,
    input  logic           i_done,
    input  pcg_pkg::t_rsp  i_rsp,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pcg_pkg::*;

    logic [MAP_W-1:0] en_bits;
    logic [DIV_W-1:0] div_tab [NUM_PERIPH];
    logic [ID_W-1:0]  sel_id;
    t_rsp             due_replies [$];

    function automatic logic periph_present(input logic [ID_W-1:0] id);
        return int'(id) < NUM_PERIPH;
    endfunction

    function automatic logic periph_gated(input logic [ID_W-1:0] id);
        return periph_present(id) && int'(id) >= FIRST_GATED;
    endfunction

    function automatic t_rsp apply_access(input t_req rq);
        t_rsp             rs;
        logic [MAP_W-1:0] stat;
        logic [MAP_W-1:0] bits;
        logic [ID_W-1:0]  id;
        rs   = '0;
        stat = (en_bits & GATED_MASK) | FORCED_MASK;
        id   = rq.wdata[ID_W-1:0];
        bits = (rq.reg_sel == REG_SET_HI || rq.reg_sel == REG_CLR_HI) ?
               {rq.wdata, 32'h0} : {32'h0, rq.wdata};
        case (rq.reg_sel)
            REG_SET_LO, REG_SET_HI: begin
                if (rq.op == OP_WRITE) en_bits = en_bits | (bits & GATED_MASK);
            end
            REG_CLR_LO, REG_CLR_HI: begin
                if (rq.op == OP_WRITE) en_bits = en_bits & ~(bits & GATED_MASK);
            end
            REG_STAT_LO: begin
                if (rq.op == OP_READ) rs.rdata = stat[31:0];
            end
            REG_STAT_HI: begin
                if (rq.op == OP_READ) rs.rdata = stat[63:32];
            end
            REG_CTRL: begin
                if (rq.op == OP_WRITE) begin
                    sel_id = id;
                    if (rq.wdata[CTL_CMD_BIT] && periph_gated(id)) begin
                        div_tab[id] = rq.wdata[CTL_DIV_SHIFT +: DIV_W];
                        en_bits[id] = rq.wdata[CTL_EN_BIT];
                    end
                end else begin
                    rs.rdata[ID_W-1:0] = sel_id;
                    if (periph_present(sel_id)) begin
                        rs.rdata[CTL_DIV_SHIFT +: DIV_W] = div_tab[sel_id];
                        rs.rdata[CTL_EN_BIT]             = stat[sel_id];
                    end
                end
            end
            default: begin
                rs.bad_reg = 1'b1;
            end
        endcase
        return rs;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            en_bits = '0;
            sel_id  = '0;
            foreach (div_tab[k]) div_tab[k] = '0;
            due_replies.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_done) begin
                if (due_replies.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: response without outstanding request: rdata %h bad_reg %b",
                             $time, i_rsp.rdata, i_rsp.bad_reg);
                end else begin
                    want = due_replies.pop_front();
                    o_checked++;
                    if (i_rsp.rdata !== want.rdata) begin
                        o_fail_count++;
                        $display("%0t: rdata mismatch: expected %h, got %h",
                                 $time, want.rdata, i_rsp.rdata);
                    end
                    if (i_rsp.bad_reg !== want.bad_reg) begin
                        o_fail_count++;
                        $display("%0t: bad_reg mismatch: expected %b, got %b",
                                 $time, want.bad_reg, i_rsp.bad_reg);
                    end
                end
            end
            if (i_start && !i_busy) due_replies.push_back(apply_access(i_req));
        end
        o_pending = due_replies.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the peripheral clock gate register test: clock, reset, directed and random
// requests with random gaps, and the verdict. Depends on pcg_pkg, pcg_gate_checker and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pcg_pkg::*;

    localparam int RAND_ITEMS = 900;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_start;
    t_req  i_req;
    logic  o_busy;
    logic  o_done;
    t_rsp  o_rsp;
    int    fail_count;
    int    pending;
    int    checked;

    int    n_items = 0;
    int    n_reads = 0;
    int    n_cmds  = 0;
    bit    quiet   = 1'b0;

    peripheral_clock_gate_regs i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    pcg_gate_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_req mk(input logic op, input logic [2:0] sel, input logic [31:0] wd);
        t_req r;
        r.op      = op;
        r.reg_sel = sel;
        r.wdata   = wd;
        return r;
    endfunction

    function automatic logic [31:0] ctl_word(input logic [5:0] id, input logic cmd,
                                             input logic [1:0] div, input logic en);
        logic [31:0] w;
        w = '0;
        w[ID_W-1:0]                 = id;
        w[CTL_CMD_BIT]              = cmd;
        w[CTL_DIV_SHIFT +: DIV_W]   = div;
        w[CTL_EN_BIT]               = en;
        return w;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input t_req r);
        i_start <= 1'b1;
        i_req   <= r;
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
        n_items++;
        if (r.op == OP_READ) n_reads++;
        if (r.reg_sel == REG_CTRL && r.op == OP_WRITE && r.wdata[CTL_CMD_BIT]) n_cmds++;
    endtask

    task automatic gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!quiet) begin
            if (r >= 92)      n = $urandom_range(8, 30);
            else if (r >= 70) n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic [5:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)  return 6'($urandom_range(0, 3));
        if (r == 2) return 6'($urandom_range(60, 63));
        return 6'($urandom_range(0, 63));
    endfunction

    initial begin
        int          kind;
        int          k;
        logic [31:0] wd;
        logic [2:0]  sel;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req   = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(mk(OP_READ,  REG_STAT_LO, 32'h0));
        issue(mk(OP_READ,  REG_STAT_HI, 32'hFFFF_FFFF));
        issue(mk(OP_READ,  REG_CTRL,    32'h0));
        issue(mk(OP_WRITE, REG_SET_LO,  32'hFFFF_FFFF));
        issue(mk(OP_READ,  REG_STAT_LO, 32'h0));
        issue(mk(OP_WRITE, REG_SET_HI,  32'hFFFF_FFFF));
        issue(mk(OP_READ,  REG_STAT_HI, 32'h0));
        issue(mk(OP_READ,  REG_SET_LO,  32'hFFFF_FFFF));
        issue(mk(OP_READ,  REG_CLR_HI,  32'hFFFF_FFFF));
        issue(mk(OP_WRITE, REG_STAT_LO, 32'h0));
        issue(mk(OP_WRITE, REG_CLR_LO,  32'hFFFF_FFFF));
        issue(mk(OP_WRITE, REG_CLR_HI,  32'h0));
        issue(mk(OP_READ,  REG_STAT_LO, 32'h0));
        issue(mk(OP_READ,  REG_STAT_HI, 32'h0));
        issue(mk(OP_WRITE, REG_CTRL,    ctl_word(6'd0, 1'b1, 2'd3, 1'b0)));
        issue(mk(OP_READ,  REG_CTRL,    32'h0));
        issue(mk(OP_WRITE, REG_CTRL,    ctl_word(6'd1, 1'b1, 2'd2, 1'b0)));
        issue(mk(OP_READ,  REG_CTRL,    32'h0));
        issue(mk(OP_WRITE, REG_CTRL,    32'hFFFF_FFC2));
        issue(mk(OP_READ,  REG_CTRL,    32'hFFFF_FFFF));
        issue(mk(OP_WRITE, REG_CTRL,    ctl_word(6'd63, 1'b1, 2'd1, 1'b1)));
        issue(mk(OP_READ,  REG_CTRL,    32'h0));
        issue(mk(OP_WRITE, REG_CTRL,    ctl_word(6'd2, 1'b0, 2'd0, 1'b1)));
        issue(mk(OP_READ,  REG_CTRL,    32'h0));
        issue(mk(OP_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF));
        issue(mk(OP_READ,  REG_UNMAPPED, 32'h0));

        k = 0;
        while (k < RAND_ITEMS) begin
            quiet = (k >= 200 && k < 300) || (k >= 600 && k < 700);
            if (k >= 450 && k < 452) begin
                i_start <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                repeat (3) @(negedge i_clk);
            end
            kind = $urandom_range(0, 99);
            wd   = $urandom;
            if (kind < 25) begin
                if ($urandom_range(0, 1)) wd = '0;
                wd[ID_W-1:0]               = pick_id();
                wd[CTL_CMD_BIT]            = 1'b1;
                wd[CTL_DIV_SHIFT +: DIV_W] = 2'($urandom_range(0, 3));
                wd[CTL_EN_BIT]             = 1'($urandom_range(0, 1));
                issue(mk(OP_WRITE, REG_CTRL, wd));
                k++;
                if ($urandom_range(0, 2) != 0) begin
                    gap();
                    issue(mk(OP_READ, REG_CTRL, $urandom));
                    k++;
                end
            end else if (kind < 35) begin
                wd[ID_W-1:0]    = pick_id();
                wd[CTL_CMD_BIT] = 1'b0;
                issue(mk(OP_WRITE, REG_CTRL, wd));
                k++;
            end else if (kind < 60) begin
                if (kind < 50) sel = $urandom_range(0, 1) ? REG_SET_HI : REG_SET_LO;
                else           sel = $urandom_range(0, 1) ? REG_CLR_HI : REG_CLR_LO;
                if ($urandom_range(0, 3) == 0) wd = wd & $urandom;
                issue(mk(OP_WRITE, sel, wd));
                k++;
            end else if (kind < 75) begin
                sel = $urandom_range(0, 1) ? REG_STAT_HI : REG_STAT_LO;
                issue(mk(OP_READ, sel, wd));
                k++;
            end else if (kind < 85) begin
                issue(mk(OP_READ, REG_CTRL, wd));
                k++;
            end else if (kind < 90) begin
                issue(mk(1'($urandom_range(0, 1)), REG_UNMAPPED, wd));
                k++;
            end else begin
                issue(mk(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), wd));
                k++;
            end
            gap();
        end

        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        $display("covered %0d requests (%0d reads, %0d control commands) over set, clear,",
                 n_items, n_reads, n_cmds);
        $display("status, control and unmapped registers; %0d responses compared", checked);
        if (fail_count == 0) begin
            $display("peripheral_clock_gate_regs verification clean");
        end else begin
            $display("peripheral_clock_gate_regs verification failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout waiting for responses");
        $display("peripheral_clock_gate_regs verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pcg_pkg.sv
rtl/pcg_ram.sv
rtl/pcg_div_store.sv
rtl/peripheral_clock_gate_regs.sv
verif/pcg_gate_checker.sv
verif/testbench.sv
